FILE: rtl/ansi_sgr_attribute_parser_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the SGR attribute parser
// Shared helpers for concurrent checks, clocked with reset disable.
// ----------------------------------------------------------------------------
`ifndef ANSI_SGR_ATTRIBUTE_PARSER_MACROS_SVH
`define ANSI_SGR_ATTRIBUTE_PARSER_MACROS_SVH

// property must hold at every rising edge outside reset
`define ASGR_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// condition must never be seen outside reset
`define ASGR_NEVER(lbl, clk, rst_n, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

FILE: rtl/asgr_pkg.sv
// ----------------------------------------------------------------------------
// SGR attribute parser package
// Byte codes, parameter codes, status codes and the result record.
// ----------------------------------------------------------------------------
package asgr_pkg;

	localparam int unsigned ACC_W = 10;

	// status codes
	localparam logic [1:0] ST_TEXT     = 2'd0;
	localparam logic [1:0] ST_PROGRESS = 2'd1;
	localparam logic [1:0] ST_ACCEPT   = 2'd2;
	localparam logic [1:0] ST_REJECT   = 2'd3;

	// bytes of interest
	localparam logic [7:0] BYTE_ESC   = 8'h1b;
	localparam logic [7:0] BYTE_LBRK  = 8'h5b;
	localparam logic [7:0] BYTE_SEMI  = 8'h3b;
	localparam logic [7:0] BYTE_FINAL = 8'h6d;
	localparam logic [7:0] BYTE_ZERO  = 8'h30;
	localparam logic [7:0] BYTE_NINE  = 8'h39;

	localparam logic [ACC_W-1:0] ACC_MAX = 10'd1023;

	// parameter codes
	localparam logic [ACC_W-1:0] CODE_RESET     = 10'd0;
	localparam logic [ACC_W-1:0] CODE_BOLD      = 10'd1;
	localparam logic [ACC_W-1:0] CODE_UNDERLINE = 10'd4;
	localparam logic [ACC_W-1:0] CODE_BLINK     = 10'd5;
	localparam logic [ACC_W-1:0] CODE_STANDOUT  = 10'd7;
	localparam logic [ACC_W-1:0] CODE_FG_CLEAR  = 10'd39;
	localparam logic [ACC_W-1:0] CODE_BG_CLEAR  = 10'd49;
	localparam logic [ACC_W-1:0] CODE_NO_COLOR  = 10'd100;
	localparam logic [ACC_W-1:0] CODE_FG_FIRST  = 10'd30;
	localparam logic [ACC_W-1:0] CODE_FG_LAST   = 10'd37;
	localparam logic [ACC_W-1:0] CODE_BG_FIRST  = 10'd40;
	localparam logic [ACC_W-1:0] CODE_BG_LAST   = 10'd47;

	// effect codes
	localparam logic [1:0] EFF_NORMAL    = 2'd0;
	localparam logic [1:0] EFF_BOLD      = 2'd1;
	localparam logic [1:0] EFF_UNDERLINE = 2'd2;
	localparam logic [1:0] EFF_STANDOUT  = 2'd3;

	// colour masks
	localparam logic [7:0] MASK_BG_KEEP = 8'hf0;
	localparam logic [7:0] MASK_FG_KEEP = 8'h0f;
	localparam logic [7:0] FG_VALID     = 8'h08;
	localparam logic [7:0] BG_VALID     = 8'h80;

	typedef struct packed {
		logic [1:0] status;
		logic [1:0] effect;
		logic [7:0] color;
	} result_t;

endpackage

FILE: rtl/ansi_sgr_attribute_parser.sv
// ----------------------------------------------------------------------------
// ANSI SGR attribute parser
// Byte stream in, parse status and committed text attributes out.
// ----------------------------------------------------------------------------
// Takes one byte per request and returns one result per byte, in order. A new
// byte is taken every clock cycle unless the result register is held by a
// stall; a byte passes the input register, then the state update into the
// result register. The rate is set by the update of phase, accumulator and
// attribute registers, which the next byte needs. A held result does not block
// the input register from filling, so at most two bytes are in flight.
module ansi_sgr_attribute_parser (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       req_valid,
	output logic       req_stall,
	input  logic [7:0] byte_in,
	input  logic       line_start,
	output logic       res_valid,
	input  logic       res_stall,
	output logic [1:0] status,
	output logic [1:0] effect,
	output logic [7:0] color
);
	import asgr_pkg::*;

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       line_start_s1;
	logic       res_valid_q;
	logic       step;
	logic       load;
	result_t    result_q;

	// s1 moves on when the result register is empty or being drained
	assign step      = valid_s1 && (!res_valid_q || !res_stall);
	assign req_stall = valid_s1 && !step;
	assign load      = req_valid && !req_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (load)
				valid_s1 <= 1'b1;
			else if (step)
				valid_s1 <= 1'b0;
			if (step)
				res_valid_q <= 1'b1;
			else if (!res_stall)
				res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			byte_s1       <= byte_in;
			line_start_s1 <= line_start;
		end
	end

	asgr_engine u_engine (
		.clk            (clk),
		.arst_n         (arst_n),
		.step           (step),
		.byte_cur       (byte_s1),
		.line_start_cur (line_start_s1),
		.result_q       (result_q)
	);

	assign res_valid = res_valid_q;
	assign status    = result_q.status;
	assign effect    = result_q.effect;
	assign color     = result_q.color;

endmodule

FILE: rtl/asgr_code_apply.sv
// ----------------------------------------------------------------------------
// SGR parameter decode
// Applies one finished numeric parameter to the tentative attributes.
// ----------------------------------------------------------------------------
module asgr_code_apply (
	input  logic [asgr_pkg::ACC_W-1:0] code,
	input  logic [1:0]                 effect_cur,
	input  logic [7:0]                 color_cur,
	output logic [1:0]                 effect_new,
	output logic [7:0]                 color_new
);
	import asgr_pkg::*;

	logic [ACC_W-1:0] fg_off;
	logic [ACC_W-1:0] bg_off;

	assign fg_off = code - CODE_FG_FIRST;
	assign bg_off = code - CODE_BG_FIRST;

	always_comb begin
		effect_new = effect_cur;
		color_new  = color_cur;
		case (code)
			CODE_RESET: begin
				effect_new = EFF_NORMAL;
				color_new  = 8'h00;
			end
			CODE_BOLD, CODE_BLINK: effect_new = EFF_BOLD;
			CODE_UNDERLINE:        effect_new = EFF_UNDERLINE;
			CODE_STANDOUT:         effect_new = EFF_STANDOUT;
			CODE_NO_COLOR:         color_new  = 8'h00;
			CODE_FG_CLEAR:         color_new  = color_cur & MASK_BG_KEEP;
			CODE_BG_CLEAR:         color_new  = color_cur & MASK_FG_KEEP;
			default: begin
				if (code >= CODE_FG_FIRST && code <= CODE_FG_LAST)
					color_new = (color_cur & MASK_BG_KEEP) | {5'b0, fg_off[2:0]} | FG_VALID;
				else if (code >= CODE_BG_FIRST && code <= CODE_BG_LAST)
					color_new = (color_cur & MASK_FG_KEEP) | {1'b0, bg_off[2:0], 4'b0}
						| BG_VALID;
			end
		endcase
	end

endmodule

FILE: rtl/asgr_engine.sv
// ----------------------------------------------------------------------------
// SGR parser state update
// Phase, accumulator and attribute registers, plus the result register.
// ----------------------------------------------------------------------------
module asgr_engine (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  logic [7:0]        byte_cur,
	input  logic              line_start_cur,
	output asgr_pkg::result_t result_q
);
	import asgr_pkg::*;

	typedef enum logic [1:0] {
		PH_IDLE,
		PH_ESC,
		PH_PARAM,
		PH_SKIP
	} phase_t;

	phase_t           phase_q, ph, ph_n;
	logic [ACC_W-1:0] acc_q, acc, acc_n;
	logic             dig_q, dig, dig_n;
	logic [1:0]       te_q, te, te_n, ce_q, ce, ce_n;
	logic [7:0]       tc_q, tc, tc_n, cc_q, cc, cc_n;
	logic [1:0]       st_n;
	logic [1:0]       ap_e;
	logic [7:0]       ap_c;
	logic [13:0]      acc_prod;
	logic             digit_hit;

	// line start wipes everything before the byte is looked at
	always_comb begin
		if (line_start_cur) begin
			ph  = PH_IDLE;
			acc = '0;
			dig = 1'b0;
			te  = EFF_NORMAL;
			tc  = 8'h00;
			ce  = EFF_NORMAL;
			cc  = 8'h00;
		end else begin
			ph  = phase_q;
			acc = acc_q;
			dig = dig_q;
			te  = te_q;
			tc  = tc_q;
			ce  = ce_q;
			cc  = cc_q;
		end
	end

	asgr_code_apply u_apply (
		.code       (acc),
		.effect_cur (te),
		.color_cur  (tc),
		.effect_new (ap_e),
		.color_new  (ap_c)
	);

	assign digit_hit = (byte_cur >= BYTE_ZERO) && (byte_cur <= BYTE_NINE);
	// acc*10 + digit; digit value is the low nibble for '0'..'9'
	assign acc_prod = ({4'b0, acc} << 3) + ({4'b0, acc} << 1) + {10'b0, byte_cur[3:0]};

	always_comb begin
		ph_n  = ph;
		acc_n = acc;
		dig_n = dig;
		te_n  = te;
		tc_n  = tc;
		ce_n  = ce;
		cc_n  = cc;
		st_n  = ST_TEXT;
		case (ph)
			PH_IDLE: begin
				if (byte_cur == BYTE_ESC) begin
					ph_n = PH_ESC;
					st_n = ST_PROGRESS;
				end
			end
			PH_ESC: begin
				if (byte_cur == BYTE_LBRK) begin
					ph_n  = PH_PARAM;
					acc_n = '0;
					dig_n = 1'b0;
					te_n  = ce;
					tc_n  = cc;
					st_n  = ST_PROGRESS;
				end else begin
					ph_n = PH_IDLE;
					st_n = ST_REJECT;
				end
			end
			PH_PARAM: begin
				if (digit_hit) begin
					acc_n = (acc_prod > {4'b0, ACC_MAX}) ? ACC_MAX : acc_prod[ACC_W-1:0];
					dig_n = 1'b1;
					st_n  = ST_PROGRESS;
				end else if (byte_cur == BYTE_SEMI) begin
					if (dig) begin
						te_n = ap_e;
						tc_n = ap_c;
					end else begin
						// empty parameter: clear and ignore the rest
						te_n = EFF_NORMAL;
						tc_n = 8'h00;
						ph_n = PH_SKIP;
					end
					acc_n = '0;
					dig_n = 1'b0;
					st_n  = ST_PROGRESS;
				end else if (byte_cur == BYTE_FINAL) begin
					te_n  = dig ? ap_e : EFF_NORMAL;
					tc_n  = dig ? ap_c : 8'h00;
					ce_n  = dig ? ap_e : EFF_NORMAL;
					cc_n  = dig ? ap_c : 8'h00;
					ph_n  = PH_IDLE;
					acc_n = '0;
					dig_n = 1'b0;
					st_n  = ST_ACCEPT;
				end else begin
					ph_n  = PH_IDLE;
					acc_n = '0;
					dig_n = 1'b0;
					st_n  = ST_REJECT;
				end
			end
			PH_SKIP: begin
				if (digit_hit || byte_cur == BYTE_SEMI) begin
					st_n = ST_PROGRESS;
				end else if (byte_cur == BYTE_FINAL) begin
					ce_n = te;
					cc_n = tc;
					ph_n = PH_IDLE;
					st_n = ST_ACCEPT;
				end else begin
					ph_n = PH_IDLE;
					st_n = ST_REJECT;
				end
			end
			default: begin
				ph_n = PH_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_IDLE;
			acc_q    <= '0;
			dig_q    <= 1'b0;
			te_q     <= EFF_NORMAL;
			tc_q     <= 8'h00;
			ce_q     <= EFF_NORMAL;
			cc_q     <= 8'h00;
			result_q <= '0;
		end else if (step) begin
			phase_q         <= ph_n;
			acc_q           <= acc_n;
			dig_q           <= dig_n;
			te_q            <= te_n;
			tc_q            <= tc_n;
			ce_q            <= ce_n;
			cc_q            <= cc_n;
			result_q.status <= st_n;
			result_q.effect <= ce_n;
			result_q.color  <= cc_n;
		end
	end

endmodule

FILE: rtl/asgr_checker.sv
// ----------------------------------------------------------------------------
// SGR parser port checker
// Concurrent checks on the top level ports, bound to the top level.
// ----------------------------------------------------------------------------
`include "ansi_sgr_attribute_parser_macros.svh"

module asgr_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       req_valid,
	input logic       req_stall,
	input logic [7:0] byte_in,
	input logic       line_start,
	input logic       res_valid,
	input logic       res_stall,
	input logic [1:0] status,
	input logic [1:0] effect,
	input logic [7:0] color
);
	logic held;
	logic req_held;
	logic in_acc;
	logic col_ok;

	assign held     = res_valid && res_stall;
	assign req_held = req_valid && req_stall;
	assign in_acc   = req_valid && !req_stall;
	// a colour nibble without its valid bit is always zero
	assign col_ok = (color[3] || color[2:0] == 3'b000) && (color[7] || color[6:4] == 3'b000);

	`ASGR_ASSERT(a_res_hold, clk, arst_n, held |=> res_valid && $stable({status, effect, color}), "result changed while stalled")
	`ASGR_ASSERT(a_req_hold, clk, arst_n, req_held |=> req_valid && $stable({byte_in, line_start}), "request changed while stalled")
	`ASGR_NEVER(a_no_stall_free, clk, arst_n, req_stall && !res_stall, "request stalled with free output")
	`ASGR_ASSERT(a_latency, clk, arst_n, (in_acc ##1 !res_stall) |=> res_valid, "result missing two cycles after request")
	`ASGR_ASSERT(a_color_form, clk, arst_n, res_valid |-> col_ok, "colour nibble set without valid bit")

endmodule

bind ansi_sgr_attribute_parser asgr_checker u_asgr_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.req_valid  (req_valid),
	.req_stall  (req_stall),
	.byte_in    (byte_in),
	.line_start (line_start),
	.res_valid  (res_valid),
	.res_stall  (res_stall),
	.status     (status),
	.effect     (effect),
	.color      (color)
);

FILE: tb/sv/ansi_sgr_attribute_parser_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SGR attribute parser testbench
// Drives directed and random byte streams of well-formed, broken and noise
// escape sequences through the request channel, with random sender gaps and
// receiver stalls. Results are checked against a local attribute predictor,
// or against the pinned expectation of a directed row.
module ansi_sgr_attribute_parser_test;
	import asgr_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 200000;
	localparam int unsigned DRAIN_CYCLES = 8;
	localparam int unsigned RANDOM_REQS = 800;
	localparam int unsigned N_PHASES = 4;

	typedef enum logic [1:0] {
		PH_IDLE  = 2'd0,
		PH_ESC   = 2'd1,
		PH_PARAM = 2'd2,
		PH_SKIP  = 2'd3
	} parse_phase_t;

	typedef struct packed {
		logic [7:0] b;
		logic       ls;
	} text_req_t;

	typedef struct packed {
		logic [7:0] b;
		logic       ls;
		logic       pinned;
		result_t    res;
	} dir_row_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       req_valid = 1'b0;
	logic       req_stall;
	logic [7:0] byte_in = 8'h00;
	logic       line_start = 1'b0;
	logic       res_valid;
	logic       res_stall = 1'b0;
	logic [1:0] status;
	logic [1:0] effect;
	logic [7:0] color;

	// typed expectation travelling with the payload
	logic       pinned = 1'b0;
	result_t    pinned_res = '0;

	int unsigned idle_pct = 0;
	int unsigned stall_pct = 0;
	int unsigned cycle_cnt = 0;
	int unsigned mismatch_cnt = 0;

	result_t   attr_expect_q[$];
	text_req_t burst_q[$];

	// predictor state
	parse_phase_t     pr_phase = PH_IDLE;
	logic [ACC_W-1:0] pr_acc = '0;
	logic             pr_digits = 1'b0;
	logic [1:0]       pr_teff = EFF_NORMAL;
	logic [7:0]       pr_tcol = 8'h00;
	logic [1:0]       pr_ceff = EFF_NORMAL;
	logic [7:0]       pr_ccol = 8'h00;

	ansi_sgr_attribute_parser uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_stall  (req_stall),
		.byte_in    (byte_in),
		.line_start (line_start),
		.res_valid  (res_valid),
		.res_stall  (res_stall),
		.status     (status),
		.effect     (effect),
		.color      (color)
	);

	always #10 clk = ~clk;

	function automatic void apply_sgr_code(input logic [ACC_W-1:0] code);
		logic [7:0]       c;
		logic [ACC_W-1:0] off;
		c = pr_tcol;
		case (code)
			CODE_RESET: begin
				pr_teff = EFF_NORMAL;
				c = 8'h00;
			end
			CODE_BOLD, CODE_BLINK: pr_teff = EFF_BOLD;
			CODE_UNDERLINE: pr_teff = EFF_UNDERLINE;
			CODE_STANDOUT: pr_teff = EFF_STANDOUT;
			CODE_NO_COLOR: c = 8'h00;
			CODE_FG_CLEAR: c = c & MASK_BG_KEEP;
			CODE_BG_CLEAR: c = c & MASK_FG_KEEP;
			default: begin
				if (code >= CODE_FG_FIRST && code <= CODE_FG_LAST) begin
					off = code - CODE_FG_FIRST;
					c = (c & MASK_BG_KEEP) | FG_VALID | {5'b0, off[2:0]};
				end else if (code >= CODE_BG_FIRST && code <= CODE_BG_LAST) begin
					off = code - CODE_BG_FIRST;
					c = (c & MASK_FG_KEEP) | BG_VALID | {1'b0, off[2:0], 4'b0};
				end
			end
		endcase
		pr_tcol = c;
	endfunction

	function automatic void clear_param();
		pr_acc = '0;
		pr_digits = 1'b0;
	endfunction

	function automatic void commit_attrs();
		pr_ceff = pr_teff;
		pr_ccol = pr_tcol;
		pr_phase = PH_IDLE;
	endfunction

	function automatic result_t predict_attrs(input logic [7:0] b, input logic ls);
		result_t     r;
		int unsigned acc_next;
		logic        num_byte;
		r.status = ST_TEXT;
		num_byte = (b >= BYTE_ZERO) && (b <= BYTE_NINE);
		if (ls) begin
			pr_phase = PH_IDLE;
			clear_param();
			pr_teff = EFF_NORMAL;
			pr_tcol = 8'h00;
			pr_ceff = EFF_NORMAL;
			pr_ccol = 8'h00;
		end
		case (pr_phase)
			PH_IDLE: begin
				if (b == BYTE_ESC) begin
					pr_phase = PH_ESC;
					r.status = ST_PROGRESS;
				end
			end
			PH_ESC: begin
				if (b == BYTE_LBRK) begin
					pr_phase = PH_PARAM;
					clear_param();
					pr_teff = pr_ceff;
					pr_tcol = pr_ccol;
					r.status = ST_PROGRESS;
				end else begin
					pr_phase = PH_IDLE;
					r.status = ST_REJECT;
				end
			end
			PH_PARAM: begin
				if (num_byte) begin
					acc_next = int'(pr_acc) * 10 + int'(b - BYTE_ZERO);
					pr_acc = (acc_next > ACC_MAX) ? ACC_MAX : acc_next[ACC_W-1:0];
					pr_digits = 1'b1;
					r.status = ST_PROGRESS;
				end else if (b == BYTE_SEMI) begin
					if (pr_digits) begin
						apply_sgr_code(pr_acc);
					end else begin
						// empty parameter: clear and skip to the final byte
						pr_teff = EFF_NORMAL;
						pr_tcol = 8'h00;
						pr_phase = PH_SKIP;
					end
					clear_param();
					r.status = ST_PROGRESS;
				end else if (b == BYTE_FINAL) begin
					if (pr_digits) begin
						apply_sgr_code(pr_acc);
					end else begin
						pr_teff = EFF_NORMAL;
						pr_tcol = 8'h00;
					end
					commit_attrs();
					clear_param();
					r.status = ST_ACCEPT;
				end else begin
					pr_phase = PH_IDLE;
					clear_param();
					r.status = ST_REJECT;
				end
			end
			default: begin
				if (num_byte || b == BYTE_SEMI) begin
					r.status = ST_PROGRESS;
				end else if (b == BYTE_FINAL) begin
					commit_attrs();
					r.status = ST_ACCEPT;
				end else begin
					pr_phase = PH_IDLE;
					r.status = ST_REJECT;
				end
			end
		endcase
		r.effect = pr_ceff;
		r.color = pr_ccol;
		return r;
	endfunction

	// results are checked before the request of the same edge is predicted
	always @(posedge clk) begin
		result_t want;
		result_t pred;
		if (arst_n) begin
			if (res_valid && !res_stall) begin
				if (attr_expect_q.size() == 0) begin
					$error("result with no request outstanding: status %0d", status);
					mismatch_cnt++;
				end else begin
					want = attr_expect_q.pop_front();
					if (status !== want.status) begin
						$error("status: expected %0d, got %0d", want.status, status);
						mismatch_cnt++;
					end
					if (effect !== want.effect) begin
						$error("effect: expected %0d, got %0d", want.effect, effect);
						mismatch_cnt++;
					end
					if (color !== want.color) begin
						$error("color: expected %02h, got %02h", want.color, color);
						mismatch_cnt++;
					end
				end
			end
			if (req_valid && !req_stall) begin
				pred = predict_attrs(byte_in, line_start);
				attr_expect_q.push_back(pinned ? pinned_res : pred);
			end
		end
	end

	always @(negedge clk) begin
		res_stall <= ($urandom_range(99) < stall_pct);
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt == CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	// entered and left just after a falling edge
	task automatic send_req(input logic [7:0] b, input logic ls, input logic pin,
			input result_t pres);
		while ($urandom_range(99) < idle_pct) begin
			req_valid <= 1'b0;
			@(negedge clk);
		end
		req_valid <= 1'b1;
		byte_in <= b;
		line_start <= ls;
		pinned <= pin;
		pinned_res <= pres;
		@(posedge clk);
		while (req_stall) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic drain_results();
		req_valid <= 1'b0;
		@(negedge clk);
		while (attr_expect_q.size() != 0) @(negedge clk);
	endtask

	function automatic void push_byte(input logic [7:0] b);
		burst_q.push_back('{b: b, ls: ($urandom_range(49) == 0)});
	endfunction

	function automatic void push_number(input int unsigned n);
		int unsigned digs[$];
		if ($urandom_range(7) == 0)
			push_byte(BYTE_ZERO);
		do begin
			digs.push_front(n % 10);
			n = n / 10;
		end while (n != 0);
		foreach (digs[i])
			push_byte(BYTE_ZERO + 8'(digs[i]));
	endfunction

	function automatic int unsigned pick_code();
		case ($urandom_range(9))
			0: return CODE_RESET;
			1: begin
				case ($urandom_range(3))
					0: return CODE_BOLD;
					1: return CODE_UNDERLINE;
					2: return CODE_BLINK;
					default: return CODE_STANDOUT;
				endcase
			end
			2, 3: return CODE_FG_FIRST + $urandom_range(7);
			4, 5: return CODE_BG_FIRST + $urandom_range(7);
			6: begin
				case ($urandom_range(2))
					0: return CODE_FG_CLEAR;
					1: return CODE_BG_CLEAR;
					default: return CODE_NO_COLOR;
				endcase
			end
			7: return $urandom_range(1023);
			8: return $urandom_range(99999);
			default: return $urandom_range(120);
		endcase
	endfunction

	function automatic void push_sequence();
		int unsigned n_params;
		n_params = $urandom_range(4);
		push_byte(BYTE_ESC);
		push_byte(BYTE_LBRK);
		for (int unsigned i = 0; i < n_params; i++) begin
			if ($urandom_range(9) != 0)
				push_number(pick_code());
			if (i + 1 < n_params)
				push_byte(BYTE_SEMI);
		end
		push_byte(BYTE_FINAL);
	endfunction

	// mostly well-formed sequences, the rest broken ones and loose bytes
	function automatic void build_burst();
		int unsigned pick;
		int unsigned k;
		burst_q.delete();
		pick = $urandom_range(99);
		if (pick < 60) begin
			push_sequence();
			repeat ($urandom_range(3))
				push_byte(8'($urandom_range(255)));
		end else if (pick < 80) begin
			push_sequence();
			k = $urandom_range(burst_q.size() - 1, 1);
			case ($urandom_range(2))
				0: burst_q[k].b = 8'($urandom_range(255));
				1: burst_q[k].b = BYTE_ESC;
				default: begin
					while (burst_q.size() > k) void'(burst_q.pop_back());
					push_byte(8'($urandom_range(255)));
				end
			endcase
		end else begin
			repeat ($urandom_range(4, 1))
				push_byte(8'($urandom_range(255)));
		end
	endfunction

	dir_row_t dir_tab [25] = '{
		'{8'h00,            1'b1, 1'b1, '{ST_TEXT,     EFF_NORMAL, 8'h00}},
		'{8'hff,            1'b0, 1'b1, '{ST_TEXT,     EFF_NORMAL, 8'h00}},
		'{BYTE_ESC,         1'b0, 1'b1, '{ST_PROGRESS, EFF_NORMAL, 8'h00}},
		'{BYTE_LBRK,        1'b0, 1'b1, '{ST_PROGRESS, EFF_NORMAL, 8'h00}},
		'{BYTE_ZERO + 8'd1, 1'b0, 1'b0, '0},
		'{BYTE_SEMI,        1'b0, 1'b0, '0},
		'{BYTE_ZERO + 8'd4, 1'b0, 1'b0, '0},
		'{BYTE_ZERO + 8'd4, 1'b0, 1'b0, '0},
		'{BYTE_FINAL,       1'b0, 1'b1, '{ST_ACCEPT,   EFF_BOLD,   8'hc0}},
		// ESC ESC breaks the introducer
		'{BYTE_ESC,         1'b0, 1'b0, '0},
		'{BYTE_ESC,         1'b0, 1'b1, '{ST_REJECT,   EFF_BOLD,   8'hc0}},
		// saturating number, then a stray byte
		'{BYTE_ESC,         1'b0, 1'b0, '0},
		'{BYTE_LBRK,        1'b0, 1'b0, '0},
		'{BYTE_ZERO + 8'd7, 1'b0, 1'b0, '0},
		'{BYTE_ZERO + 8'd7, 1'b0, 1'b0, '0},
		'{BYTE_ZERO + 8'd7, 1'b0, 1'b0, '0},
		'{BYTE_ZERO + 8'd7, 1'b0, 1'b0, '0},
		'{8'h71,            1'b0, 1'b1, '{ST_REJECT,   EFF_BOLD,   8'hc0}},
		// empty parameter clears, the rest is skipped
		'{BYTE_ESC,         1'b0, 1'b0, '0},
		'{BYTE_LBRK,        1'b0, 1'b0, '0},
		'{BYTE_SEMI,        1'b0, 1'b0, '0},
		'{BYTE_ZERO + 8'd3, 1'b0, 1'b0, '0},
		'{BYTE_FINAL,       1'b0, 1'b1, '{ST_ACCEPT,   EFF_NORMAL, 8'h00}},
		// line start drops a half-open sequence
		'{BYTE_ESC,         1'b0, 1'b0, '0},
		'{BYTE_ZERO + 8'd5, 1'b1, 1'b1, '{ST_TEXT,     EFF_NORMAL, 8'h00}}
	};

	initial begin
		text_req_t   item;
		int unsigned sent;
		sent = 0;
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;

		foreach (dir_tab[i])
			send_req(dir_tab[i].b, dir_tab[i].ls, dir_tab[i].pinned, dir_tab[i].res);
		drain_results();

		for (int unsigned ph = 0; ph < N_PHASES; ph++) begin
			case (ph)
				0: begin idle_pct = 0;  stall_pct = 0;  end
				1: begin idle_pct = 67; stall_pct = 0;  end
				2: begin idle_pct = 0;  stall_pct = 67; end
				default: begin idle_pct = 19; stall_pct = 19; end
			endcase
			while (sent < (ph + 1) * RANDOM_REQS / N_PHASES) begin
				build_burst();
				while (burst_q.size() != 0) begin
					item = burst_q.pop_front();
					send_req(item.b, item.ls, 1'b0, '0);
					sent++;
				end
			end
			// hold off until everything outstanding has come back
			drain_results();
		end

		repeat (DRAIN_CYCLES) @(negedge clk);
		if (mismatch_cnt == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
